// ===== rtl/core/h2r_pkg.sv =====
`default_nettype none

package h2r_pkg;

	// field widths
	localparam int unsigned HUE_W = 13;
	localparam int unsigned CH_W  = 8;

	// hue geometry in sixteenths of a degree
	localparam int unsigned SECTOR_SPAN = 960;
	localparam int unsigned HUE_CIRCLE  = 5760;
	localparam int unsigned FRAC_FULL   = 255;
	localparam int unsigned QT_DENOM    = FRAC_FULL * SECTOR_SPAN;

	// internal widths
	localparam int unsigned SEC_W  = 3;
	localparam int unsigned REM_W  = 10;
	localparam int unsigned PROD_W = 18;
	localparam int unsigned PN_W   = 2 * CH_W;
	localparam int unsigned NUM_W  = CH_W + PROD_W;

	// reciprocal for exact division of the q/t numerators by QT_DENOM
	localparam int unsigned QT_SHIFT = NUM_W + PROD_W;
	localparam longint unsigned QT_RECIP =
		((64'd1 << QT_SHIFT) + QT_DENOM - 1) / QT_DENOM;
	localparam int unsigned QT_RECIP_W = 27;
	localparam int unsigned QT_MUL_W   = NUM_W + QT_RECIP_W;

	// reciprocal for exact division of the p numerator by 255
	localparam int unsigned P_SHIFT = PN_W + CH_W;
	localparam longint unsigned P_RECIP =
		((64'd1 << P_SHIFT) + FRAC_FULL - 1) / FRAC_FULL;
	localparam int unsigned P_RECIP_W = 17;
	localparam int unsigned P_MUL_W   = PN_W + P_RECIP_W;

	// 60-degree hue sectors
	typedef enum logic [SEC_W-1:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

endpackage

`default_nettype wire

// ===== rtl/core/h2r_in_if.sv =====
`default_nettype none

interface h2r_in_if
	import h2r_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation;
	logic [CH_W-1:0]  brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/h2r_out_if.sv =====
`default_nettype none

interface h2r_out_if
	import h2r_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_converter_top.sv =====
// five register stages, s1 to s5; an accepted item is registered into each in turn, then shown at the output
// throughput: one item per clock; the pipeline holds as a whole while the output is stalled
// every stage, the reciprocal multipliers feeding stage four included, takes one item per cycle while it moves
// reset: arst_n clears all stage valid bits asynchronously; payload registers are not reset
`default_nettype none

module hsv_to_rgb_converter_top
	import h2r_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	h2r_in_if.sink     pix_in,
	h2r_out_if.source  pix_out
);

	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1 payload
	sector_t            sec_s1;
	logic [REM_W-1:0]   rem_s1;
	logic [CH_W-1:0]    sat_s1;
	logic [CH_W-1:0]    val_s1;
	// stage 2 payload
	sector_t            sec_s2;
	logic [CH_W-1:0]    val_s2;
	logic [PROD_W-1:0]  sr_s2;
	logic [PROD_W-1:0]  st_s2;
	logic [PN_W-1:0]    pn_s2;
	// stage 3 payload
	sector_t            sec_s3;
	logic [CH_W-1:0]    val_s3;
	logic [NUM_W-1:0]   qx_s3;
	logic [NUM_W-1:0]   tx_s3;
	logic [PN_W-1:0]    pn_s3;
	// stage 4 payload
	sector_t            sec_s4;
	logic [CH_W-1:0]    val_s4;
	logic [CH_W-1:0]    qm_s4;
	logic [CH_W-1:0]    tm_s4;
	logic [CH_W-1:0]    pm_s4;
	// stage 5 payload
	logic [CH_W-1:0]    red_s5;
	logic [CH_W-1:0]    green_s5;
	logic [CH_W-1:0]    blue_s5;

	// whole pipeline moves unless a result is held at the output
	assign adv          = !vld_s5 || pix_out.ready;
	assign pix_in.ready = adv;

	// hue wrap and sector split
	logic [HUE_W-1:0] hue_w;
	sector_t          sec_d;
	logic [HUE_W-1:0] base_d;
	logic [HUE_W-1:0] rem_full;

	always_comb begin
		if (pix_in.hue >= HUE_W'(HUE_CIRCLE)) begin
			hue_w = pix_in.hue - HUE_W'(HUE_CIRCLE);
		end else begin
			hue_w = pix_in.hue;
		end
		priority if (hue_w >= HUE_W'(5 * SECTOR_SPAN)) begin
			sec_d  = SEC_M_R;
			base_d = HUE_W'(5 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(4 * SECTOR_SPAN)) begin
			sec_d  = SEC_B_M;
			base_d = HUE_W'(4 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(3 * SECTOR_SPAN)) begin
			sec_d  = SEC_C_B;
			base_d = HUE_W'(3 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(2 * SECTOR_SPAN)) begin
			sec_d  = SEC_G_C;
			base_d = HUE_W'(2 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(SECTOR_SPAN)) begin
			sec_d  = SEC_Y_G;
			base_d = HUE_W'(SECTOR_SPAN);
		end else begin
			sec_d  = SEC_R_Y;
			base_d = '0;
		end
		rem_full = hue_w - base_d;
	end

	// stage 2 products
	logic [REM_W-1:0]  crem_d;
	logic [PROD_W-1:0] sr_d;
	logic [PROD_W-1:0] st_d;
	logic [PN_W-1:0]   pn_d;

	assign crem_d = REM_W'(SECTOR_SPAN) - rem_s1;
	assign sr_d   = PROD_W'(sat_s1) * PROD_W'(rem_s1);
	assign st_d   = PROD_W'(sat_s1) * PROD_W'(crem_d);
	assign pn_d   = PN_W'(val_s1) * PN_W'(CH_W'(FRAC_FULL) - sat_s1);

	// stage 3 numerators of q and t
	logic [PROD_W-1:0] qa_d;
	logic [PROD_W-1:0] ta_d;
	logic [NUM_W-1:0]  qx_d;
	logic [NUM_W-1:0]  tx_d;

	assign qa_d = PROD_W'(QT_DENOM) - sr_s2;
	assign ta_d = PROD_W'(QT_DENOM) - st_s2;
	assign qx_d = NUM_W'(val_s2) * NUM_W'(qa_d);
	assign tx_d = NUM_W'(val_s2) * NUM_W'(ta_d);

	// stage 4 exact division by reciprocal multiply
	logic [QT_MUL_W-1:0] qprod;
	logic [QT_MUL_W-1:0] tprod;
	logic [P_MUL_W-1:0]  pprod;

	assign qprod = QT_MUL_W'(qx_s3) * QT_MUL_W'(QT_RECIP);
	assign tprod = QT_MUL_W'(tx_s3) * QT_MUL_W'(QT_RECIP);
	assign pprod = P_MUL_W'(pn_s3) * P_MUL_W'(P_RECIP);

	// stage 5 sector routing
	logic [CH_W-1:0] red_d, green_d, blue_d;

	always_comb begin
		unique case (sec_s4)
			SEC_R_Y: begin
				red_d = val_s4; green_d = tm_s4;  blue_d = pm_s4;
			end
			SEC_Y_G: begin
				red_d = qm_s4;  green_d = val_s4; blue_d = pm_s4;
			end
			SEC_G_C: begin
				red_d = pm_s4;  green_d = val_s4; blue_d = tm_s4;
			end
			SEC_C_B: begin
				red_d = pm_s4;  green_d = qm_s4;  blue_d = val_s4;
			end
			SEC_B_M: begin
				red_d = tm_s4;  green_d = pm_s4;  blue_d = val_s4;
			end
			default: begin
				red_d = val_s4; green_d = pm_s4;  blue_d = qm_s4;
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s1   <= sec_d;
			rem_s1   <= rem_full[REM_W-1:0];
			sat_s1   <= pix_in.saturation;
			val_s1   <= pix_in.brightness;

			sec_s2   <= sec_s1;
			val_s2   <= val_s1;
			sr_s2    <= sr_d;
			st_s2    <= st_d;
			pn_s2    <= pn_d;

			sec_s3   <= sec_s2;
			val_s3   <= val_s2;
			qx_s3    <= qx_d;
			tx_s3    <= tx_d;
			pn_s3    <= pn_s2;

			sec_s4   <= sec_s3;
			val_s4   <= val_s3;
			qm_s4    <= qprod[QT_SHIFT +: CH_W];
			tm_s4    <= tprod[QT_SHIFT +: CH_W];
			pm_s4    <= pprod[P_SHIFT +: CH_W];

			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
		end
	end

	assign pix_out.valid = vld_s5;
	assign pix_out.red   = red_s5;
	assign pix_out.green = green_s5;
	assign pix_out.blue  = blue_s5;

	// sector split stays inside one sector
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (rem_s1 < REM_W'(SECTOR_SPAN)))
		else $error("sector remainder out of range");

	// the p, q and t terms never exceed the brightness
	a_terms_le_v: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (pm_s4 <= val_s4 && qm_s4 <= val_s4 && tm_s4 <= val_s4))
		else $error("color term above brightness");

	// a stalled pipeline keeps its items in place
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !adv) |=> (vld_s4 && $stable(qm_s4) && $stable(sec_s4)))
		else $error("stage four item lost during stall");

	// an item accepted while moving reaches stage one
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready) |=> vld_s1)
		else $error("accepted item missing from stage one");

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_converter_top_tb.sv =====
`timescale 1ns / 100ps

module hsv_to_rgb_converter_top_tb;
	import h2r_pkg::*;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// one pixel waiting to be sent, with its lead-in gap
	typedef struct {
		hsv_t        px;
		int unsigned idle_before;
		bit          wait_drain;
	} pixel_job_t;

	localparam int unsigned RANDOM_PIXELS = 1600;
	localparam int unsigned CALM_TAIL     = 150;
	localparam int unsigned MAX_PRINTS    = 100;

	logic clk = 1'b0;
	logic arst_n;

	h2r_in_if  pix_in_bus ();
	h2r_out_if pix_out_bus ();

	hsv_to_rgb_converter_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	pixel_job_t  pixel_jobs[$];
	rgb_t        expected_rgb[$];
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_total = 0;
	int unsigned error_count = 0;
	int unsigned send_idle = 0;
	int unsigned stall_left = 0;
	bit          choppy_out = 1'b1;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// six-sector conversion in exact integer arithmetic
	function automatic rgb_t hsv_to_rgb(hsv_t px);
		int unsigned h, idx, pos;
		longint unsigned s, v, p, q, t;
		sector_t sec;
		rgb_t c;
		h = px.hue;
		s = px.saturation;
		v = px.brightness;
		if (s == 0) begin
			c.red   = px.brightness;
			c.green = px.brightness;
			c.blue  = px.brightness;
		end else begin
			if (h >= HUE_CIRCLE) begin
				h = h - HUE_CIRCLE;
			end
			idx = h / SECTOR_SPAN;
			pos = h - idx * SECTOR_SPAN;
			sec = sector_t'(idx);
			p = (v * (FRAC_FULL - s)) / FRAC_FULL;
			q = (v * (QT_DENOM - s * pos)) / QT_DENOM;
			t = (v * (QT_DENOM - s * (SECTOR_SPAN - pos))) / QT_DENOM;
			case (sec)
				SEC_R_Y: begin
					c = '{CH_W'(v), CH_W'(t), CH_W'(p)};
				end
				SEC_Y_G: begin
					c = '{CH_W'(q), CH_W'(v), CH_W'(p)};
				end
				SEC_G_C: begin
					c = '{CH_W'(p), CH_W'(v), CH_W'(t)};
				end
				SEC_C_B: begin
					c = '{CH_W'(p), CH_W'(q), CH_W'(v)};
				end
				SEC_B_M: begin
					c = '{CH_W'(t), CH_W'(p), CH_W'(v)};
				end
				default: begin
					c = '{CH_W'(v), CH_W'(p), CH_W'(q)};
				end
			endcase
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		error_count++;
	endtask

	task automatic add_pixel(input int unsigned hue, input int unsigned sat,
		input int unsigned bri, input int unsigned idle, input bit drain);
		pixel_job_t job;
		job.px.hue        = HUE_W'(hue);
		job.px.saturation = CH_W'(sat);
		job.px.brightness = CH_W'(bri);
		job.idle_before   = idle;
		job.wait_drain    = drain;
		pixel_jobs.insert(pixel_jobs.size(), job);
		n_total++;
	endtask

	// channel value weighted toward the ends of the range
	function automatic int unsigned pick_channel();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: pick_channel = 0;
			1: pick_channel = 255;
			2: pick_channel = $urandom_range(0, 1) ? 1 : 254;
			default: pick_channel = $urandom_range(0, 255);
		endcase
	endfunction

	// hue weighted toward sector edges and the wrap region
	function automatic int unsigned pick_hue();
		int unsigned sel;
		int h;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: begin
				h = $urandom_range(0, 6) * SECTOR_SPAN + $urandom_range(0, 2) - 1;
				if (h < 0) begin
					h = 0;
				end
				pick_hue = h;
			end
			2: pick_hue = $urandom_range(HUE_CIRCLE, (1 << HUE_W) - 1);
			default: pick_hue = $urandom_range(0, HUE_CIRCLE - 1);
		endcase
	endfunction

	// input driver: presents the head job, pops it when taken
	always @(posedge clk) begin
		bit took;
		bit free;
		if (arst_n) begin
			took = pix_in_bus.valid && pix_in_bus.ready;
			if (took) begin
				void'(pixel_jobs.pop_front());
				n_accepted <= n_accepted + 1;
			end
			free = took || !pix_in_bus.valid;
			if (free) begin
				if (pixel_jobs.size() == 0) begin
					pix_in_bus.valid <= 1'b0;
				end else if (send_idle < pixel_jobs[0].idle_before) begin
					send_idle++;
					pix_in_bus.valid <= 1'b0;
				end else if (pixel_jobs[0].wait_drain && (took || n_accepted != n_checked)) begin
					pix_in_bus.valid <= 1'b0;
				end else begin
					send_idle = 0;
					pix_in_bus.valid      <= 1'b1;
					pix_in_bus.hue        <= pixel_jobs[0].px.hue;
					pix_in_bus.saturation <= pixel_jobs[0].px.saturation;
					pix_in_bus.brightness <= pixel_jobs[0].px.brightness;
				end
			end
		end
	end

	// output monitor: checks results, records expectations, drives ready
	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		hsv_t px;
		if (arst_n) begin
			if (pix_out_bus.valid && pix_out_bus.ready) begin
				got = '{pix_out_bus.red, pix_out_bus.green, pix_out_bus.blue};
				if (expected_rgb.size() == 0) begin
					report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
						got.red, got.green, got.blue));
				end else begin
					want = expected_rgb.pop_front();
					n_checked <= n_checked + 1;
					if (got.red !== want.red) begin
						report_mismatch($sformatf("item %0d red %0d, expected %0d",
							n_checked, got.red, want.red));
					end
					if (got.green !== want.green) begin
						report_mismatch($sformatf("item %0d green %0d, expected %0d",
							n_checked, got.green, want.green));
					end
					if (got.blue !== want.blue) begin
						report_mismatch($sformatf("item %0d blue %0d, expected %0d",
							n_checked, got.blue, want.blue));
					end
				end
			end

			// expectation for the item taken at this edge
			if (pix_in_bus.valid && pix_in_bus.ready) begin
				px = '{pix_in_bus.hue, pix_in_bus.saturation, pix_in_bus.brightness};
				expected_rgb.insert(expected_rgb.size(), hsv_to_rgb(px));
			end

			// ready stalls in bursts, none near the end
			if (stall_left != 0) begin
				stall_left--;
				pix_out_bus.ready <= 1'b0;
			end else if (choppy_out && n_checked + CALM_TAIL < n_total
				&& $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				pix_out_bus.ready <= 1'b0;
			end else begin
				pix_out_bus.ready <= 1'b1;
			end
			if ($urandom_range(0, 63) == 0) begin
				choppy_out = !choppy_out;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		bit gaps_on;
		int unsigned idle;
		arst_n                 = 1'b0;
		pix_in_bus.valid       = 1'b0;
		pix_in_bus.hue         = '0;
		pix_in_bus.saturation  = '0;
		pix_in_bus.brightness  = '0;
		pix_out_bus.ready      = 1'b0;

		// directed: sector edges, wrap, grey and channel extremes
		add_pixel(0, 255, 255, 0, 0);
		add_pixel(HUE_CIRCLE, 255, 255, 0, 0);
		add_pixel(HUE_CIRCLE + 1, 200, 180, 0, 0);
		add_pixel((1 << HUE_W) - 1, 255, 255, 0, 0);
		add_pixel(SECTOR_SPAN - 1, 255, 255, 0, 0);
		add_pixel(SECTOR_SPAN, 128, 200, 0, 0);
		add_pixel(2 * SECTOR_SPAN - 1, 1, 255, 0, 0);
		add_pixel(2 * SECTOR_SPAN, 255, 1, 0, 0);
		add_pixel(3 * SECTOR_SPAN, 77, 240, 0, 0);
		add_pixel(4 * SECTOR_SPAN, 255, 255, 0, 0);
		add_pixel(5 * SECTOR_SPAN, 255, 255, 0, 0);
		add_pixel(HUE_CIRCLE - 1, 255, 255, 0, 0);
		add_pixel(480, 255, 255, 0, 0);
		add_pixel(1440, 255, 128, 0, 0);
		add_pixel(2400, 170, 90, 0, 0);
		add_pixel(3360, 254, 254, 0, 0);
		add_pixel(4320, 1, 1, 0, 0);
		add_pixel(5280, 255, 0, 0, 0);
		add_pixel(1234, 0, 200, 0, 0);
		add_pixel((1 << HUE_W) - 1, 0, 255, 0, 0);
		add_pixel(0, 0, 0, 0, 0);
		add_pixel(7000, 0, 99, 0, 0);
		add_pixel(5000, 128, 0, 0, 0);

		// random: segments with and without gaps, drains along the way
		for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % 100 == 0) begin
				gaps_on = $urandom_range(0, 2) != 0;
			end
			idle = 0;
			if (gaps_on && i + CALM_TAIL < RANDOM_PIXELS && $urandom_range(0, 3) == 0) begin
				idle = $urandom_range(1, 14);
			end
			add_pixel(pick_hue(), pick_channel(), pick_channel(), idle,
				i == 0 || i == RANDOM_PIXELS / 2);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every item to go in and every result to come out
		while (pixel_jobs.size() != 0 || pix_in_bus.valid) begin
			@(posedge clk);
		end
		while (n_checked < n_accepted) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (expected_rgb.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_rgb.size()));
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout: %0d of %0d results checked", n_checked, n_total);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
